// File: rtl/avpd_pkg.sv
package avpd_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;

    // Register field widths and reset values
    localparam int IMAGE_WIDTH_W      = 11;
    localparam int IMAGE_HEIGHT_W     = 13;
    localparam int BPP_W              = 3;
    localparam int IMAGE_WIDTH_RESET  = 1024;
    localparam int IMAGE_HEIGHT_RESET = 1;
    localparam int BPP_RESET          = 3;

    // Row counter and its ceiling
    localparam int ROW_CNT_W = 12;
    localparam int MAX_ROWS  = 4096;

    // Payload width
    localparam int BYTE_W = 8;

    // Default geometry of the line store
    localparam int DEF_MAX_WIDTH      = 1024;
    localparam int DEF_MAX_COMPONENTS = 4;

    // Average predictor: mean of both neighbors, else the one present, else zero
    function automatic logic [BYTE_W-1:0] avpd_predict(
        input logic [BYTE_W-1:0] left,
        input logic [BYTE_W-1:0] above,
        input logic              has_left,
        input logic              has_above
    );
        logic [BYTE_W:0]   sum;
        logic [BYTE_W-1:0] pred;
        sum = {1'b0, left} + {1'b0, above};
        if (has_left && has_above)
        begin
            pred = sum[BYTE_W:1];
        end
        else if (has_left)
        begin
            pred = left;
        end
        else if (has_above)
        begin
            pred = above;
        end
        else
        begin
            pred = '0;
        end
        return pred;
    endfunction

endpackage

// File: rtl/avpd_in_if.sv
interface avpd_in_if;
    import avpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] residual_byte;

    modport source (output valid, output residual_byte, input ready);
    modport sink   (input valid, input residual_byte, output ready);
endinterface

// File: rtl/avpd_out_if.sv
interface avpd_out_if;
    import avpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte;
    logic              image_last;

    modport source (output valid, output pixel_byte, output image_last, input ready);
    modport sink   (input valid, input pixel_byte, input image_last, output ready);
endinterface

// File: rtl/avpd_cfg_if.sv
interface avpd_cfg_if;
    import avpd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/average_predictor_defilter.sv
// Average-predictor defilter: rebuilds image bytes from residuals.
//
// residual (sink): one residual byte per transaction, raster order, component
//   by component within each pixel.
// pixel (source): one rebuilt byte per accepted residual, in order, with
//   image_last high on the final byte of the image; counters then wrap.
// cfg (sink): register writes (width, height, bytes per pixel), always ready;
//   write only while no residual is in flight.
// Timing: an accepted residual is held in the compute stage, then stored in
//   the result register once that register is empty or being taken, and is
//   visible on pixel from then on.
// Throughput: one byte per clock while pixel is taken. The line store is read
//   at accept time and written when the byte leaves the compute stage; a one-entry
//   bypass covers a same-entry read and write at one edge (one-pixel, one-byte rows).
// Reset: counters, left pixel and registers return to their reset values at
//   once; the line store is not cleared and no clearing pass runs.
// Stall: while pixel is not taken, the result register holds; one more residual
//   is accepted into the compute stage, then residual.ready drops.
module average_predictor_defilter #(
    parameter int MAX_WIDTH      = avpd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_COMPONENTS = avpd_pkg::DEF_MAX_COMPONENTS
) (
    input  logic              clk,
    input  logic              rst_n,
    avpd_in_if.sink           residual,
    avpd_out_if.source        pixel,
    avpd_cfg_if.sink          cfg
);
    import avpd_pkg::*;

    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WLIM_W  = $clog2(MAX_WIDTH + 1);
    localparam int COMP_W  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int CLIM_W  = $clog2(MAX_COMPONENTS + 1);
    localparam int DEPTH   = MAX_WIDTH * MAX_COMPONENTS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WIDTH_RESET_EFF =
        (MAX_WIDTH < IMAGE_WIDTH_RESET) ? MAX_WIDTH : IMAGE_WIDTH_RESET;
    localparam int COMP_RESET_EFF =
        (MAX_COMPONENTS < BPP_RESET) ? MAX_COMPONENTS : BPP_RESET;

    // Effective (clamped) limits
    logic [WLIM_W-1:0]         width_lim_reg;
    logic [IMAGE_HEIGHT_W-1:0] height_lim_reg;
    logic [CLIM_W-1:0]         comp_lim_reg;

    // Position counters
    logic [COL_W-1:0]     column_count_reg, column_count_next;
    logic [ROW_CNT_W-1:0] row_count_reg, row_count_next;
    logic [COMP_W-1:0]    comp_count_reg, comp_count_next;

    // Compute stage
    logic                s1_valid_reg;
    logic [BYTE_W-1:0]   s1_res_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic [COMP_W-1:0]   s1_comp_reg;
    logic                s1_has_left_reg;
    logic                s1_has_above_reg;
    logic                s1_last_reg;
    logic                bypass_sel_reg;
    logic [BYTE_W-1:0]   bypass_data_reg;
    logic [BYTE_W-1:0]   mem_rd_reg;

    // Line store and left pixel lanes
    logic [BYTE_W-1:0]   row_store [DEPTH];
    logic [BYTE_W-1:0]   left_pixel_reg [MAX_COMPONENTS];

    // Result register
    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_pixel_reg;
    logic                out_last_reg;

    logic                in_fire;
    logic                s1_advance;
    logic                last_comp;
    logic                last_col;
    logic                last_row;
    logic [ADDR_W-1:0]   rd_addr;
    logic [BYTE_W-1:0]   s1_above;
    logic [BYTE_W-1:0]   s1_pix;

    logic [IMAGE_WIDTH_W-1:0]  cfg_width_val;
    logic [IMAGE_HEIGHT_W-1:0] cfg_height_val;
    logic [BPP_W-1:0]          cfg_bpp_val;

    // Handshakes
    assign s1_advance     = s1_valid_reg && (!out_valid_reg || pixel.ready);
    assign residual.ready = !s1_valid_reg || s1_advance;
    assign in_fire        = residual.valid && residual.ready;
    assign cfg.ready      = 1'b1;

    assign pixel.valid      = out_valid_reg;
    assign pixel.pixel_byte = out_pixel_reg;
    assign pixel.image_last = out_last_reg;

    // Configuration writes, clamped on entry
    assign cfg_width_val  = cfg.data[IMAGE_WIDTH_W-1:0];
    assign cfg_height_val = cfg.data[IMAGE_HEIGHT_W-1:0];
    assign cfg_bpp_val    = cfg.data[BPP_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_lim_reg  <= WLIM_W'(WIDTH_RESET_EFF);
            height_lim_reg <= IMAGE_HEIGHT_W'(IMAGE_HEIGHT_RESET);
            comp_lim_reg   <= CLIM_W'(COMP_RESET_EFF);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:
                begin
                    if (cfg_width_val == '0)
                        width_lim_reg <= WLIM_W'(1);
                    else if (32'(cfg_width_val) > 32'(MAX_WIDTH))
                        width_lim_reg <= WLIM_W'(MAX_WIDTH);
                    else
                        width_lim_reg <= WLIM_W'(cfg_width_val);
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (cfg_height_val == '0)
                        height_lim_reg <= IMAGE_HEIGHT_W'(1);
                    else if (32'(cfg_height_val) > 32'(MAX_ROWS))
                        height_lim_reg <= IMAGE_HEIGHT_W'(MAX_ROWS);
                    else
                        height_lim_reg <= cfg_height_val;
                end
                REG_BYTES_PER_PIXEL:
                begin
                    if (cfg_bpp_val == '0)
                        comp_lim_reg <= CLIM_W'(1);
                    else if (32'(cfg_bpp_val) > 32'(MAX_COMPONENTS))
                        comp_lim_reg <= CLIM_W'(MAX_COMPONENTS);
                    else
                        comp_lim_reg <= CLIM_W'(cfg_bpp_val);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Position of the arriving byte and where the counters go next
    assign last_comp = (32'(comp_count_reg) + 32'd1) >= 32'(comp_lim_reg);
    assign last_col  = (32'(column_count_reg) + 32'd1) >= 32'(width_lim_reg);
    assign last_row  = (32'(row_count_reg) + 32'd1) >= 32'(height_lim_reg);
    assign rd_addr   = ADDR_W'(32'(column_count_reg) * 32'(MAX_COMPONENTS)
                               + 32'(comp_count_reg));

    always_comb
    begin
        comp_count_next   = comp_count_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (!last_comp)
        begin
            comp_count_next = comp_count_reg + COMP_W'(1);
        end
        else
        begin
            comp_count_next = '0;
            if (!last_col)
            begin
                column_count_next = column_count_reg + COL_W'(1);
            end
            else
            begin
                column_count_next = '0;
                if (!last_row)
                    row_count_next = row_count_reg + ROW_CNT_W'(1);
                else
                    row_count_next = '0;
            end
        end
    end

    // Advance counters on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_count_reg   <= '0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (in_fire)
        begin
            comp_count_reg   <= comp_count_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // Compute stage: predict and add
    assign s1_above = bypass_sel_reg ? bypass_data_reg : mem_rd_reg;
    assign s1_pix   = s1_res_reg + avpd_predict(left_pixel_reg[s1_comp_reg], s1_above,
                                                s1_has_left_reg, s1_has_above_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (residual.ready)
        begin
            s1_valid_reg <= residual.valid;
        end
    end

    // Capture the byte, its position and the bypass choice
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_res_reg       <= residual.residual_byte;
            s1_addr_reg      <= rd_addr;
            s1_comp_reg      <= comp_count_reg;
            s1_has_left_reg  <= (column_count_reg != '0);
            s1_has_above_reg <= (row_count_reg != '0);
            s1_last_reg      <= last_comp && last_col && last_row;
            bypass_sel_reg   <= s1_advance && (s1_addr_reg == rd_addr);
            bypass_data_reg  <= s1_pix;
        end
    end

    // Line store: read at accept, write as the byte leaves the compute stage
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mem_rd_reg <= row_store[rd_addr];
        end
        if (s1_advance)
        begin
            row_store[s1_addr_reg] <= s1_pix;
        end
    end

    // Hold the last pixel's components
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_COMPONENTS; i++)
            begin
                left_pixel_reg[i] <= '0;
            end
        end
        else if (s1_advance)
        begin
            left_pixel_reg[s1_comp_reg] <= s1_pix;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pixel.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_pixel_reg <= s1_pix;
            out_last_reg  <= s1_last_reg;
        end
    end

    // Checks
    a_bypass_on_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s1_advance && (s1_addr_reg == rd_addr) |=> bypass_sel_reg)
        else $error("bypass not selected for a read of the entry being written");

    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_comp && last_col && last_row |=>
            (comp_count_reg == '0) && (column_count_reg == '0) && (row_count_reg == '0))
        else $error("counters did not wrap after the last byte");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_addr_reg)
            && $stable(s1_res_reg))
        else $error("compute stage changed while stalled");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without an item in the compute stage");

endmodule

// File: verif/avpd_checker.sv
module avpd_checker
    import avpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    avpd_in_if   residual,
    avpd_out_if  pixel,
    avpd_cfg_if  cfg,
    output int   fail_count,
    output int   pending_count,
    output int   result_count,
    output int   image_count,
    output logic at_boundary
);

    localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_COMPONENTS;
    localparam int COL_W       = $clog2(DEF_MAX_WIDTH);
    localparam int COMP_W      = $clog2(DEF_MAX_COMPONENTS);
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel_byte;
        logic              image_last;
    } rebuilt_t;

    // Register copies, as written on the configuration channel
    logic [IMAGE_WIDTH_W-1:0]  width_reg;
    logic [IMAGE_HEIGHT_W-1:0] height_reg;
    logic [BPP_W-1:0]          bpp_reg;

    // Image position and neighbor history
    logic [BYTE_W-1:0]                    line_store [STORE_DEPTH];
    logic [DEF_MAX_COMPONENTS*BYTE_W-1:0] last_pixel;
    logic [COL_W-1:0]                     column_pos;
    logic [ROW_CNT_W-1:0]                 row_pos;
    logic [COMP_W-1:0]                    comp_pos;

    rebuilt_t rebuilt_fifo [$];
    int       results_taken;
    int       images_taken;

    // Zero acts as one, anything above the ceiling acts as the ceiling
    function automatic int effective(input int value, input int ceiling);
        if (value == 0)
        begin
            return 1;
        end
        return (value > ceiling) ? ceiling : value;
    endfunction

    // Rebuild one component byte and advance the raster position
    function automatic rebuilt_t defilter_byte(input logic [BYTE_W-1:0] res);
        int                w_eff;
        int                h_eff;
        int                n_eff;
        int                slot;
        logic [BYTE_W-1:0] left_b;
        logic [BYTE_W-1:0] above_b;
        logic [BYTE_W-1:0] guess;
        logic [BYTE_W:0]   pair_sum;
        logic              last_comp;
        logic              last_col;
        logic              last_row;
        rebuilt_t          r;
        w_eff    = effective(int'(width_reg), DEF_MAX_WIDTH);
        h_eff    = effective(int'(height_reg), MAX_ROWS);
        n_eff    = effective(int'(bpp_reg), DEF_MAX_COMPONENTS);
        slot     = int'(column_pos) * DEF_MAX_COMPONENTS + int'(comp_pos);
        left_b   = last_pixel[comp_pos*BYTE_W +: BYTE_W];
        above_b  = line_store[slot];
        pair_sum = {1'b0, left_b} + {1'b0, above_b};

        // Mean of both neighbors, else whichever exists, else zero
        if (column_pos != '0 && row_pos != '0)
        begin
            guess = pair_sum[BYTE_W:1];
        end
        else if (column_pos != '0)
        begin
            guess = left_b;
        end
        else if (row_pos != '0)
        begin
            guess = above_b;
        end
        else
        begin
            guess = '0;
        end

        r.pixel_byte = res + guess;
        line_store[slot] = r.pixel_byte;
        last_pixel[comp_pos*BYTE_W +: BYTE_W] = r.pixel_byte;

        // Counters beyond a lowered limit still wrap at their next step
        last_comp = (int'(comp_pos) + 1 >= n_eff);
        last_col  = (int'(column_pos) + 1 >= w_eff);
        last_row  = (int'(row_pos) + 1 >= h_eff);
        r.image_last = last_comp && last_col && last_row;

        if (!last_comp)
        begin
            comp_pos = comp_pos + 1'b1;
        end
        else
        begin
            comp_pos = '0;
            if (!last_col)
            begin
                column_pos = column_pos + 1'b1;
            end
            else
            begin
                column_pos = '0;
                row_pos    = last_row ? '0 : row_pos + 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [BYTE_W-1:0] got_v,
                          input logic [BYTE_W-1:0] want_v);
        if (fail_count < MAX_PRINTED)
        begin
            $display("mismatch on result %0d: %s, got %0h, expected %0h",
                     results_taken, what, got_v, want_v);
        end
        fail_count++;
    endtask

    // Compare outgoing transactions, track register writes, predict incoming ones
    always @(posedge clk or negedge rst_n)
    begin : watch
        rebuilt_t got;
        rebuilt_t want;
        if (!rst_n)
        begin
            width_reg     = IMAGE_WIDTH_W'(IMAGE_WIDTH_RESET);
            height_reg    = IMAGE_HEIGHT_W'(IMAGE_HEIGHT_RESET);
            bpp_reg       = BPP_W'(BPP_RESET);
            last_pixel    = '0;
            column_pos    = '0;
            row_pos       = '0;
            comp_pos      = '0;
            results_taken = 0;
            images_taken  = 0;
            fail_count    = 0;
            rebuilt_fifo.delete();
            pending_count <= 0;
            result_count  <= 0;
            image_count   <= 0;
            at_boundary   <= 1'b1;
        end
        else
        begin
            if (pixel.valid && pixel.ready)
            begin
                got.pixel_byte = pixel.pixel_byte;
                got.image_last = pixel.image_last;
                if (rebuilt_fifo.size() == 0)
                begin
                    report("result with nothing outstanding", got.pixel_byte, '0);
                end
                else
                begin
                    want = rebuilt_fifo.pop_front();
                    if (got.pixel_byte !== want.pixel_byte)
                    begin
                        report("pixel_byte", got.pixel_byte, want.pixel_byte);
                    end
                    if (got.image_last !== want.image_last)
                    begin
                        report("image_last", BYTE_W'(got.image_last),
                               BYTE_W'(want.image_last));
                    end
                    if (want.image_last)
                    begin
                        images_taken++;
                    end
                end
                results_taken++;
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_IMAGE_WIDTH:     width_reg  = cfg.data[IMAGE_WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT:    height_reg = cfg.data[IMAGE_HEIGHT_W-1:0];
                    REG_BYTES_PER_PIXEL: bpp_reg    = cfg.data[BPP_W-1:0];
                    default:             ;
                endcase
            end

            if (residual.valid && residual.ready)
            begin
                rebuilt_fifo.push_back(defilter_byte(residual.residual_byte));
            end

            pending_count <= rebuilt_fifo.size();
            result_count  <= results_taken;
            image_count   <= images_taken;
            at_boundary   <= (column_pos == '0) && (row_pos == '0) && (comp_pos == '0);
        end
    end

endmodule

// File: verif/tb.sv
module tb;
    import avpd_pkg::*;

    // Index with no register behind it; writes to it must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 550;
    localparam int WIDE_PREFIX_BYTES = 20;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;

    avpd_in_if  residual ();
    avpd_out_if pixel ();
    avpd_cfg_if cfg ();

    int   fail_count;
    int   pending_count;
    int   result_count;
    int   image_count;
    logic at_boundary;

    int bytes_sent;
    int reg_writes;
    int phases;
    int quiet_cycles;
    bit steady;

    // Two-component 2x3 image whose neighbors sit at 0x00 and 0xFF
    logic [BYTE_W-1:0] corner_bytes [12] = '{
        8'hFF, 8'h00, 8'h00, 8'h01,
        8'h00, 8'hFF, 8'h80, 8'h7F,
        8'hFF, 8'h01, 8'h00, 8'hFF
    };
    logic [BYTE_W-1:0] one_byte_images [3] = '{8'h00, 8'hFF, 8'h55};

    average_predictor_defilter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .residual (residual),
        .pixel    (pixel),
        .cfg      (cfg)
    );

    avpd_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .residual      (residual),
        .pixel         (pixel),
        .cfg           (cfg),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .image_count   (image_count),
        .at_boundary   (at_boundary)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [BYTE_W-1:0] random_residual();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return '1;
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Pick an encoding for an effective register value: zero for one,
    // an oversized bytes-per-pixel count for the top, junk above the register's width
    function automatic logic [CFG_DATA_W-1:0] encode_reg(input logic [CFG_INDEX_W-1:0] idx,
                                                         input int eff);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'(eff);
        if (eff == 1 && $urandom_range(0, 2) == 0)
        begin
            v = '0;
        end
        if (idx == REG_IMAGE_WIDTH)
        begin
            v[CFG_DATA_W-1:IMAGE_WIDTH_W] = (CFG_DATA_W - IMAGE_WIDTH_W)'($urandom);
        end
        else if (idx == REG_BYTES_PER_PIXEL)
        begin
            if (eff == DEF_MAX_COMPONENTS && $urandom_range(0, 2) == 0)
            begin
                v = CFG_DATA_W'($urandom_range(5, 7));
            end
            v[CFG_DATA_W-1:BPP_W] = (CFG_DATA_W - BPP_W)'($urandom);
        end
        return v;
    endfunction

    // Offer one residual and hold it until taken; valid stays high afterwards
    task automatic send_residual(input logic [BYTE_W-1:0] value);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            residual.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        residual.valid         <= 1'b1;
        residual.residual_byte <= value;
        @(posedge clk);
        while (!residual.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic stream(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_residual(random_residual());
        end
        if (count > 0)
        begin
            residual.valid <= 1'b0;
        end
    endtask

    // Wait until every rebuilt byte has left the block
    task automatic wait_idle();
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        reg_writes++;
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] width_v,
                                input logic [CFG_DATA_W-1:0] height_v,
                                input logic [CFG_DATA_W-1:0] bpp_v,
                                input bit with_spare);
        write_reg(REG_IMAGE_WIDTH, width_v);
        write_reg(REG_IMAGE_HEIGHT, height_v);
        write_reg(REG_BYTES_PER_PIXEL, bpp_v);
        if (with_spare)
        begin
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        end
        cfg.valid <= 1'b0;
    endtask

    // Feed single bytes until the raster position is back at the image start
    task automatic drain_to_boundary();
        wait_idle();
        while (!at_boundary)
        begin
            send_residual(random_residual());
            residual.valid <= 1'b0;
            wait_idle();
        end
    endtask

    // One random geometry: whole images, or one image cut by a lowered register
    task automatic random_phase();
        int                     w;
        int                     h;
        int                     n;
        int                     size;
        int                     eff;
        logic [CFG_INDEX_W-1:0] idx;
        w = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        h = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        n = $urandom_range(1, DEF_MAX_COMPONENTS);
        size = w * h * n;
        steady = ($urandom_range(0, 3) == 0);
        phases++;
        program_regs(encode_reg(REG_IMAGE_WIDTH, w), encode_reg(REG_IMAGE_HEIGHT, h),
                     encode_reg(REG_BYTES_PER_PIXEL, n), $urandom_range(0, 5) == 0);
        if ($urandom_range(0, 3) == 0)
        begin
            stream($urandom_range(1, size));
            wait_idle();
            idx = CFG_INDEX_W'($urandom_range(REG_IMAGE_WIDTH, REG_BYTES_PER_PIXEL));
            if (idx == REG_IMAGE_WIDTH)
            begin
                eff = $urandom_range(1, w);
            end
            else if (idx == REG_IMAGE_HEIGHT)
            begin
                eff = $urandom_range(1, h);
            end
            else
            begin
                eff = $urandom_range(1, n);
            end
            write_reg(idx, encode_reg(idx, eff));
            cfg.valid <= 1'b0;
            stream($urandom_range(0, 8));
            drain_to_boundary();
        end
        else
        begin
            stream($urandom_range(1, 3) * size);
            wait_idle();
        end
    endtask

    // Output side: random stalls, plus one long hold-off to back the block up
    initial
    begin : pixel_side
        int  run;
        int  stall;
        bit  held;
        held = 1'b0;
        pixel.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held && result_count >= HOLD_AT)
            begin
                pixel.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            pixel.ready <= 1'b1;
            run = $urandom_range(1, 40);
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall != 0)
            begin
                pixel.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Abort when no transaction of any kind moves for too long
    always @(posedge clk)
    begin
        if ((residual.valid && residual.ready) || (pixel.valid && pixel.ready) ||
            (cfg.valid && cfg.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no transaction for %0d cycles, %0d bytes outstanding",
                     quiet_cycles, pending_count);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int random_start;
        residual.valid         <= 1'b0;
        residual.residual_byte <= '0;
        cfg.valid              <= 1'b0;
        cfg.index              <= REG_IMAGE_WIDTH;
        cfg.data               <= '0;
        rst_n                  <= 1'b0;
        bytes_sent = 0;
        reg_writes = 0;
        phases     = 0;
        steady     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Saturated neighbors: sums that carry into the ninth bit
        program_regs(CFG_DATA_W'(2), CFG_DATA_W'(3), CFG_DATA_W'(2), 1'b0);
        foreach (corner_bytes[i])
        begin
            send_residual(corner_bytes[i]);
        end
        residual.valid <= 1'b0;
        wait_idle();

        // All registers zero: every byte is a whole image
        program_regs('0, '0, '0, 1'b1);
        foreach (one_byte_images[i])
        begin
            send_residual(one_byte_images[i]);
        end
        residual.valid <= 1'b0;
        wait_idle();

        // Oversized height, then lowered below the current row mid image
        write_reg(REG_IMAGE_HEIGHT, '1);
        cfg.valid <= 1'b0;
        stream(6);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        cfg.valid <= 1'b0;
        drain_to_boundary();

        // Oversized width, then lowered below the current column mid row
        program_regs('1, CFG_DATA_W'(2), '0, 1'b0);
        stream(WIDE_PREFIX_BYTES);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
        cfg.valid <= 1'b0;
        stream(5);
        drain_to_boundary();

        random_start = bytes_sent;
        while (bytes_sent < random_start + RANDOM_ITEMS)
        begin
            random_phase();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d residual bytes, %0d images finished, %0d register writes",
                 bytes_sent, image_count, reg_writes);
        $display("%0d random geometries after clamped and mid-image register cases",
                 phases);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/avpd_pkg.sv
rtl/avpd_in_if.sv
rtl/avpd_out_if.sv
rtl/avpd_cfg_if.sv
rtl/average_predictor_defilter.sv
verif/avpd_checker.sv
verif/tb.sv
